// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned CP_W = 21;

    // sequence lengths of the open sequence
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // code point limits
    localparam logic [CP_W-1:0] MIN_TWO   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR  = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

    // one decoded code point waiting for output
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            pair;
    } unit_job_t;

    // front to queue
    typedef struct packed {
        logic      push;
        unit_job_t job;
    } queue_push_t;

    // queue to back
    typedef struct packed {
        logic      valid;
        unit_job_t job;
    } queue_head_t;

endpackage

// ===== rtl/u8u16_front.sv =====
module u8u16_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_in_byte,
    input  logic                    s_end_of_string,
    input  logic                    q_full,
    output u8u16_pkg::queue_push_t  push_o
);
    import u8u16_pkg::*;

    logic [CP_W-1:0] cp_reg, cp_next;
    logic [1:0]      need_reg, need_next;
    logic [2:0]      len_reg, len_next;
    logic            accept;
    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] min_cp;
    logic            fin_ok;
    logic            as_lead;
    logic            push;
    unit_job_t       job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign shifted = {cp_reg[CP_W-7:0], s_in_byte[5:0]};

    // smallest legal value for the open sequence length
    always_comb begin
        unique case (len_reg)
            SEQ_TWO:   min_cp = MIN_TWO;
            SEQ_THREE: min_cp = MIN_THREE;
            default:   min_cp = MIN_FOUR;
        endcase
    end

    assign fin_ok = (shifted >= min_cp) && (shifted <= CP_MAX)
                    && !((shifted >= SURR_LO) && (shifted <= SURR_HI));

    // byte classification and sequence tracking
    always_comb begin
        cp_next   = cp_reg;
        need_next = need_reg;
        len_next  = len_reg;
        push      = 1'b0;
        job.cp    = shifted;
        job.pair  = shifted > BMP_MAX;
        as_lead   = 1'b1;
        if (need_reg != 2'd0) begin
            if (s_in_byte[7:6] == 2'b10) begin
                as_lead   = 1'b0;
                cp_next   = shifted;
                need_next = need_reg - 2'd1;
                if (need_reg == 2'd1) begin
                    push     = fin_ok;
                    cp_next  = '0;
                    len_next = SEQ_NONE;
                end
            end else begin
                cp_next   = '0;
                need_next = 2'd0;
                len_next  = SEQ_NONE;
            end
        end
        if (as_lead) begin
            priority if (s_in_byte[7] == 1'b0) begin
                push     = 1'b1;
                job.cp   = {{(CP_W-8){1'b0}}, s_in_byte};
                job.pair = 1'b0;
            end else if (s_in_byte[7:5] == 3'b110) begin
                cp_next   = {{(CP_W-5){1'b0}}, s_in_byte[4:0]};
                need_next = 2'd1;
                len_next  = SEQ_TWO;
            end else if (s_in_byte[7:4] == 4'b1110) begin
                cp_next   = {{(CP_W-4){1'b0}}, s_in_byte[3:0]};
                need_next = 2'd2;
                len_next  = SEQ_THREE;
            end else if (s_in_byte[7:3] == 5'b11110) begin
                cp_next   = {{(CP_W-3){1'b0}}, s_in_byte[2:0]};
                need_next = 2'd3;
                len_next  = SEQ_FOUR;
            end else begin
                // stray continuation or invalid lead: dropped
                cp_next = cp_next;
            end
        end
        if (s_end_of_string) begin
            cp_next   = '0;
            need_next = 2'd0;
            len_next  = SEQ_NONE;
        end
    end

    assign push_o.push = push && accept;
    assign push_o.job  = job;

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_reg   <= '0;
            need_reg <= 2'd0;
            len_reg  <= SEQ_NONE;
        end else if (accept) begin
            cp_reg   <= cp_next;
            need_reg <= need_next;
            len_reg  <= len_next;
        end
    end

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_string) |=> (need_reg == 2'd0 && len_reg == SEQ_NONE))
        else $error("end of string left a sequence open");

    a_len_covers_need: assert property (@(posedge aclk) disable iff (!aresetn)
        (need_reg != 2'd0) |-> (len_reg > {1'b0, need_reg}))
        else $error("bytes still needed exceed sequence length");

endmodule

// ===== rtl/u8u16_queue.sv =====
module u8u16_queue #(
    parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  u8u16_pkg::queue_push_t  push_i,
    input  logic                    pop,
    output logic                    full,
    output u8u16_pkg::queue_head_t  head_o
);
    import u8u16_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    unit_job_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full         = (count_reg == FULL_CNT);
    assign head_o.valid = (count_reg != '0);
    assign head_o.job   = mem[rd_ptr_reg];
    assign do_pop       = pop && head_o.valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i.push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push_i.push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push_i.push) begin
            mem[wr_ptr_reg] <= push_i.job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push_i.push)
        else $error("push into a full queue");

endmodule

// ===== rtl/u8u16_back.sv =====
module u8u16_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  u8u16_pkg::queue_head_t  head_i,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [15:0]             m_code_unit,
    output logic                    m_last_of_run
);
    import u8u16_pkg::*;

    logic            phase_reg, phase_next;
    logic [CP_W-1:0] offset;
    logic [15:0]     high_unit;
    logic [15:0]     low_unit;
    logic            take;

    // surrogate pair split
    assign offset    = head_i.job.cp - MIN_FOUR;
    assign high_unit = HIGH_SURR_BASE + {6'b0, offset[19:10]};
    assign low_unit  = LOW_SURR_BASE + {6'b0, offset[9:0]};

    assign m_valid       = head_i.valid;
    assign take          = m_valid && m_ready;
    assign m_last_of_run = !head_i.job.pair || phase_reg;
    assign m_code_unit   = !head_i.job.pair ? head_i.job.cp[15:0]
                         : (phase_reg ? low_unit : high_unit);
    assign pop           = take && m_last_of_run;

    // which half of a pair is on the output
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            phase_next = !m_last_of_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    a_phase_on_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (head_i.valid && head_i.job.pair))
        else $error("low surrogate phase without a pair at the head");

endmodule

// ===== rtl/utf8_to_utf16_decoder_top.sv =====
// output: a decoded code point is written into the queue and drives the outputs once it reaches its head
// throughput: one byte per cycle while the queue is not full; a surrogate pair goes out as high then low unit
// the queue of QUEUE_DEPTH decoded code points absorbs pairs and output stalls
// reset: aresetn synchronous active low, clears sequence state, queue and pair phase
module utf8_to_utf16_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_last_of_run
);
    import u8u16_pkg::*;

    queue_push_t push;
    queue_head_t head;
    logic        q_full;
    logic        pop;

    // byte classification
    u8u16_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_string (s_end_of_string),
        .q_full          (q_full),
        .push_o          (push)
    );

    // decoded code point queue
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .pop     (pop),
        .full    (q_full),
        .head_o  (head)
    );

    // code unit output
    u8u16_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_i        (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_last_of_run (m_last_of_run)
    );

endmodule
